// ===== hw/rtl/ddrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ddrm_pkg
// Shared types and constants for the ramped differential-drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddrm_pkg;

    // throttle word width, 1.0 = 2^(THROTTLE_BITS-1)
    localparam int THROTTLE_BITS = 16;
    localparam logic [THROTTLE_BITS-1:0] THR_FULL = {1'b0, {(THROTTLE_BITS-1){1'b1}}};

    // fixed scale factors
    localparam logic [15:0] FWD_SCALE = 16'd2000;
    localparam logic [15:0] MS_SCALE  = 16'd1000;

    // serial unit sizes
    localparam int SU_W     = 64;
    localparam int REM_W    = 50;
    localparam int MPLR_W   = 16;
    localparam int CNT_W    = 6;
    localparam logic [CNT_W-1:0] MUL_STEPS   = 6'd16;
    localparam logic [CNT_W-1:0] LIM_STEPS   = 6'd36;
    localparam logic [CNT_W-1:0] THR_STEPS   = CNT_W'(THROTTLE_BITS - 1);

    // register map (word index)
    localparam logic [2:0] REG_LIN_ACCEL = 3'd0;
    localparam logic [2:0] REG_ANG_ACCEL = 3'd1;
    localparam logic [2:0] REG_WHEEL_BASE = 3'd2;
    localparam logic [2:0] REG_WHEEL_DIAM = 3'd3;
    localparam logic [2:0] REG_GAIN_LEFT = 3'd4;
    localparam logic [2:0] REG_GAIN_RIGHT = 3'd5;
    localparam logic [2:0] REG_SUPPLY_MV = 3'd6;

    typedef struct packed {
        logic signed [15:0] goal_speed;
        logic signed [15:0] goal_turn;
        logic [15:0]        elapsed_ms;
        logic               clear;
    } t_in;

    typedef struct packed {
        logic signed [THROTTLE_BITS-1:0] left_drive;
        logic signed [THROTTLE_BITS-1:0] right_drive;
        logic signed [15:0]              ramped_speed;
        logic signed [15:0]              ramped_turn;
        logic                            left_clipped;
        logic                            right_clipped;
    } t_out;

    typedef struct packed {
        logic [15:0] lin_accel;
        logic [15:0] ang_accel;
        logic [9:0]  wheel_base;
        logic [7:0]  wheel_diam;
        logic [15:0] gain_left;
        logic [15:0] gain_right;
        logic [15:0] supply_mv;
    } t_cfg;

    typedef enum logic {
        SU_MUL,
        SU_DIV
    } t_su_op;

    typedef struct packed {
        logic              start;
        t_su_op            op;
        logic [SU_W-1:0]   opa;
        logic [REM_W-1:0]  rem;
        logic [MPLR_W-1:0] opb;
        logic [REM_W-1:0]  den;
        logic [CNT_W-1:0]  count;
    } t_su_cmd;

    typedef struct packed {
        logic            done;
        logic [SU_W-1:0] acc;
    } t_su_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SL_MUL, S_SL_MUL_W, S_SL_DIV, S_SL_DIV_W,
        S_TL_MUL, S_TL_MUL_W, S_TL_DIV, S_TL_DIV_W,
        S_FWD, S_FWD_W, S_TRN, S_TRN_W, S_DEN, S_DEN_W,
        S_GAIN, S_GAIN_W, S_K, S_K_W, S_Q, S_Q_W,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/diff_drive_ramped_mixer_top.sv =====
// ----------------------------------------------------------------------------
// diff_drive_ramped_mixer_top
// Slew-limited differential-drive mixer producing left/right throttles.
// ----------------------------------------------------------------------------
// One request at a time is worked through a single bit-serial multiply/divide
// unit under a sequencer. A request with elapsed_ms above one runs two
// 16-step multiplies and two 36-step divides for the ramp limits, then the
// wheel products and two 15-step throttle divides; without the ramp it runs
// only the wheel products and the throttle divides. Each side whose throttle
// comes out zero or saturated skips its divide. The serial unit works one bit
// per cycle. The next request is taken while the previous result still waits
// in the output register; a finished result that finds that register still
// full holds the sequencer until it drains. Configuration must be written
// through the APB port only while the block is idle; the user is bound to
// this, and the block itself does not enforce it.
`default_nettype none

module diff_drive_ramped_mixer_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ddrm_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output ddrm_pkg::t_out      o_out,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);

    localparam int TB = ddrm_pkg::THROTTLE_BITS;

    ddrm_pkg::t_cfg    w_cfg;
    ddrm_pkg::t_su_cmd w_cmd;
    ddrm_pkg::t_su_rsp w_rsp;

    ddrm_pkg::t_state  r_state, n_state;
    logic              r_side, n_side;
    logic              r_ovalid, n_ovalid;
    logic signed [15:0] r_hs, n_hs, r_ht, n_ht;
    logic signed [15:0] r_gs, n_gs, r_gt, n_gt;
    logic [15:0]       r_ms, n_ms;
    logic [26:0]       r_fwd, n_fwd;
    logic [25:0]       r_trn, n_trn;
    logic [47:0]       r_den, n_den;
    logic              r_neg, n_neg;
    logic [52:0]       r_a, n_a;
    logic [TB-1:0]     r_lthr, n_lthr, r_rthr, n_rthr;
    logic              r_lclip, n_lclip, r_rclip, n_rclip;
    ddrm_pkg::t_out    r_out, n_out;

    logic [27:0]       w_wheel;
    logic [27:0]       w_mag;
    logic [TB-1:0]     w_q;

    ddrm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ddrm_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    // move cur toward goal by at most lim
    function automatic logic [15:0] slew(input logic [15:0] cur, input logic [15:0] goal,
                                         input logic [26:0] lim);
        logic [16:0] d;
        logic [16:0] mag;
        logic [15:0] res;
        d   = {goal[15], goal} - {cur[15], cur};
        mag = d[16] ? (17'd0 - d) : d;
        if ({10'd0, mag} > lim) begin
            res = d[16] ? (cur - lim[15:0]) : (cur + lim[15:0]);
        end else begin
            res = goal;
        end
        return res;
    endfunction

    assign o_in_ready  = (r_state == ddrm_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // wheel rate for the side in work
    assign w_wheel = r_side ? ({r_fwd[26], r_fwd} - {{2{r_trn[25]}}, r_trn})
                            : ({r_fwd[26], r_fwd} + {{2{r_trn[25]}}, r_trn});
    assign w_mag   = w_wheel[27] ? (28'd0 - w_wheel) : w_wheel;
    assign w_q     = r_neg ? (TB'(0) - {1'b0, w_rsp.acc[TB-2:0]})
                           : {1'b0, w_rsp.acc[TB-2:0]};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_side   = r_side;
        n_ovalid = r_ovalid;
        n_hs = r_hs; n_ht = r_ht; n_gs = r_gs; n_gt = r_gt; n_ms = r_ms;
        n_fwd = r_fwd; n_trn = r_trn; n_den = r_den; n_neg = r_neg; n_a = r_a;
        n_lthr = r_lthr; n_rthr = r_rthr; n_lclip = r_lclip; n_rclip = r_rclip;
        n_out = r_out;
        w_cmd       = '0;
        w_cmd.op    = ddrm_pkg::SU_MUL;
        w_cmd.count = ddrm_pkg::MUL_STEPS;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ddrm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_gs = i_in.goal_speed;
                    n_gt = i_in.goal_turn;
                    n_ms = i_in.elapsed_ms;
                    if (i_in.clear) begin
                        n_gs = '0; n_gt = '0; n_hs = '0; n_ht = '0;
                    end
                    n_state = (i_in.elapsed_ms > 16'd1) ? ddrm_pkg::S_SL_MUL
                                                        : ddrm_pkg::S_FWD;
                end
            end
            // linear ramp limit: accel * ms * 16 / 1000
            ddrm_pkg::S_SL_MUL: begin
                w_cmd.start = 1'b1;
                w_cmd.opa   = {48'd0, w_cfg.lin_accel};
                w_cmd.opb   = r_ms;
                n_state     = ddrm_pkg::S_SL_MUL_W;
            end
            ddrm_pkg::S_SL_MUL_W: if (w_rsp.done) n_state = ddrm_pkg::S_SL_DIV;
            ddrm_pkg::S_SL_DIV: begin
                w_cmd.start = 1'b1;
                w_cmd.op    = ddrm_pkg::SU_DIV;
                w_cmd.opa   = {w_rsp.acc[31:0], 32'd0};
                w_cmd.den   = {34'd0, ddrm_pkg::MS_SCALE};
                w_cmd.count = ddrm_pkg::LIM_STEPS;
                n_state     = ddrm_pkg::S_SL_DIV_W;
            end
            ddrm_pkg::S_SL_DIV_W: begin
                if (w_rsp.done) begin
                    n_hs    = slew(r_hs, r_gs, w_rsp.acc[26:0]);
                    n_state = ddrm_pkg::S_TL_MUL;
                end
            end
            // angular ramp limit
            ddrm_pkg::S_TL_MUL: begin
                w_cmd.start = 1'b1;
                w_cmd.opa   = {48'd0, w_cfg.ang_accel};
                w_cmd.opb   = r_ms;
                n_state     = ddrm_pkg::S_TL_MUL_W;
            end
            ddrm_pkg::S_TL_MUL_W: if (w_rsp.done) n_state = ddrm_pkg::S_TL_DIV;
            ddrm_pkg::S_TL_DIV: begin
                w_cmd.start = 1'b1;
                w_cmd.op    = ddrm_pkg::SU_DIV;
                w_cmd.opa   = {w_rsp.acc[31:0], 32'd0};
                w_cmd.den   = {34'd0, ddrm_pkg::MS_SCALE};
                w_cmd.count = ddrm_pkg::LIM_STEPS;
                n_state     = ddrm_pkg::S_TL_DIV_W;
            end
            ddrm_pkg::S_TL_DIV_W: begin
                if (w_rsp.done) begin
                    n_ht    = slew(r_ht, r_gt, w_rsp.acc[26:0]);
                    n_state = ddrm_pkg::S_FWD;
                end
            end
            // speed * 2000
            ddrm_pkg::S_FWD: begin
                w_cmd.start = 1'b1;
                w_cmd.opa   = {{48{r_hs[15]}}, r_hs};
                w_cmd.opb   = ddrm_pkg::FWD_SCALE;
                n_state     = ddrm_pkg::S_FWD_W;
            end
            ddrm_pkg::S_FWD_W: begin
                if (w_rsp.done) begin
                    n_fwd   = w_rsp.acc[26:0];
                    n_state = ddrm_pkg::S_TRN;
                end
            end
            // turn * wheel base
            ddrm_pkg::S_TRN: begin
                w_cmd.start = 1'b1;
                w_cmd.opa   = {{48{r_ht[15]}}, r_ht};
                w_cmd.opb   = {6'd0, w_cfg.wheel_base};
                n_state     = ddrm_pkg::S_TRN_W;
            end
            ddrm_pkg::S_TRN_W: begin
                if (w_rsp.done) begin
                    n_trn   = w_rsp.acc[25:0];
                    n_state = ddrm_pkg::S_DEN;
                end
            end
            // divisor: diameter * millivolts * 2^24
            ddrm_pkg::S_DEN: begin
                w_cmd.start = 1'b1;
                w_cmd.opa   = {56'd0, w_cfg.wheel_diam};
                w_cmd.opb   = w_cfg.supply_mv;
                n_state     = ddrm_pkg::S_DEN_W;
            end
            ddrm_pkg::S_DEN_W: begin
                if (w_rsp.done) begin
                    n_den   = {w_rsp.acc[23:0], 24'd0};
                    n_side  = 1'b0;
                    n_state = ddrm_pkg::S_GAIN;
                end
            end
            // |wheel| * gain
            ddrm_pkg::S_GAIN: begin
                w_cmd.start = 1'b1;
                w_cmd.opa   = {37'd0, w_mag[26:0]};
                w_cmd.opb   = r_side ? w_cfg.gain_right : w_cfg.gain_left;
                n_neg       = w_wheel[27];
                n_state     = ddrm_pkg::S_GAIN_W;
            end
            ddrm_pkg::S_GAIN_W: if (w_rsp.done) n_state = ddrm_pkg::S_K;
            // * 1000
            ddrm_pkg::S_K: begin
                w_cmd.start = 1'b1;
                w_cmd.opa   = w_rsp.acc;
                w_cmd.opb   = ddrm_pkg::MS_SCALE;
                n_state     = ddrm_pkg::S_K_W;
            end
            ddrm_pkg::S_K_W: begin
                if (w_rsp.done) begin
                    n_a = w_rsp.acc[52:0];
                    if (w_rsp.acc == '0) begin
                        // zero numerator: no drive, no clip
                        if (r_side) begin
                            n_rthr = '0; n_rclip = 1'b0; n_state = ddrm_pkg::S_DONE;
                        end else begin
                            n_lthr = '0; n_lclip = 1'b0; n_side = 1'b1;
                            n_state = ddrm_pkg::S_GAIN;
                        end
                    end else if (w_rsp.acc >= {16'd0, r_den}) begin
                        // saturate with the wheel's sign
                        if (r_side) begin
                            n_rthr  = r_neg ? (TB'(0) - ddrm_pkg::THR_FULL) : ddrm_pkg::THR_FULL;
                            n_rclip = 1'b1;
                            n_state = ddrm_pkg::S_DONE;
                        end else begin
                            n_lthr  = r_neg ? (TB'(0) - ddrm_pkg::THR_FULL) : ddrm_pkg::THR_FULL;
                            n_lclip = 1'b1;
                            n_side  = 1'b1;
                            n_state = ddrm_pkg::S_GAIN;
                        end
                    end else begin
                        n_state = ddrm_pkg::S_Q;
                    end
                end
            end
            // fractional quotient a / den
            ddrm_pkg::S_Q: begin
                w_cmd.start = 1'b1;
                w_cmd.op    = ddrm_pkg::SU_DIV;
                w_cmd.rem   = r_a[49:0];
                w_cmd.den   = {2'd0, r_den};
                w_cmd.count = ddrm_pkg::THR_STEPS;
                n_state     = ddrm_pkg::S_Q_W;
            end
            ddrm_pkg::S_Q_W: begin
                if (w_rsp.done) begin
                    if (r_side) begin
                        n_rthr = w_q; n_rclip = 1'b0; n_state = ddrm_pkg::S_DONE;
                    end else begin
                        n_lthr = w_q; n_lclip = 1'b0; n_side = 1'b1;
                        n_state = ddrm_pkg::S_GAIN;
                    end
                end
            end
            // hand over once the output register is free
            ddrm_pkg::S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out.left_drive     = r_lthr;
                    n_out.right_drive    = r_rthr;
                    n_out.ramped_speed   = r_hs;
                    n_out.ramped_turn    = r_ht;
                    n_out.left_clipped   = r_lclip;
                    n_out.right_clipped  = r_rclip;
                    n_ovalid             = 1'b1;
                    n_state              = ddrm_pkg::S_IDLE;
                end
            end
            default: n_state = ddrm_pkg::S_IDLE;
        endcase
    end

    // control and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ddrm_pkg::S_IDLE;
            r_side   <= 1'b0;
            r_ovalid <= 1'b0;
            r_hs     <= '0;
            r_ht     <= '0;
        end else begin
            r_state  <= n_state;
            r_side   <= n_side;
            r_ovalid <= n_ovalid;
            r_hs     <= n_hs;
            r_ht     <= n_ht;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_gs <= n_gs; r_gt <= n_gt; r_ms <= n_ms;
        r_fwd <= n_fwd; r_trn <= n_trn; r_den <= n_den;
        r_neg <= n_neg; r_a <= n_a;
        r_lthr <= n_lthr; r_rthr <= n_rthr;
        r_lclip <= n_lclip; r_rclip <= n_rclip;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ddrm_cfg.sv =====
// ----------------------------------------------------------------------------
// ddrm_cfg
// APB-style register file holding the mixer configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrm_cfg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output ddrm_pkg::t_cfg        o_cfg
);

    ddrm_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lin_accel  <= 16'd256;
            r_cfg.ang_accel  <= 16'd256;
            r_cfg.wheel_base <= 10'd150;
            r_cfg.wheel_diam <= 8'd65;
            r_cfg.gain_left  <= 16'd4096;
            r_cfg.gain_right <= 16'd4096;
            r_cfg.supply_mv  <= 16'd7400;
        end else if (w_wr) begin
            case (paddr[4:2])
                ddrm_pkg::REG_LIN_ACCEL:  r_cfg.lin_accel  <= pwdata[15:0];
                ddrm_pkg::REG_ANG_ACCEL:  r_cfg.ang_accel  <= pwdata[15:0];
                ddrm_pkg::REG_WHEEL_BASE: r_cfg.wheel_base <= pwdata[9:0];
                ddrm_pkg::REG_WHEEL_DIAM: r_cfg.wheel_diam <= pwdata[7:0];
                ddrm_pkg::REG_GAIN_LEFT:  r_cfg.gain_left  <= pwdata[15:0];
                ddrm_pkg::REG_GAIN_RIGHT: r_cfg.gain_right <= pwdata[15:0];
                ddrm_pkg::REG_SUPPLY_MV:  r_cfg.supply_mv  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[4:2])
            ddrm_pkg::REG_LIN_ACCEL:  prdata = {16'd0, r_cfg.lin_accel};
            ddrm_pkg::REG_ANG_ACCEL:  prdata = {16'd0, r_cfg.ang_accel};
            ddrm_pkg::REG_WHEEL_BASE: prdata = {22'd0, r_cfg.wheel_base};
            ddrm_pkg::REG_WHEEL_DIAM: prdata = {24'd0, r_cfg.wheel_diam};
            ddrm_pkg::REG_GAIN_LEFT:  prdata = {16'd0, r_cfg.gain_left};
            ddrm_pkg::REG_GAIN_RIGHT: prdata = {16'd0, r_cfg.gain_right};
            ddrm_pkg::REG_SUPPLY_MV:  prdata = {16'd0, r_cfg.supply_mv};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ddrm_serial.sv =====
// ----------------------------------------------------------------------------
// ddrm_serial
// Bit-serial arithmetic unit: shift-add multiply and restoring divide,
// one bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrm_serial (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire ddrm_pkg::t_su_cmd i_cmd,
    output ddrm_pkg::t_su_rsp o_rsp
);

    logic                              r_busy, r_done;
    ddrm_pkg::t_su_op                  r_op;
    logic [ddrm_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [ddrm_pkg::SU_W-1:0]         r_acc, n_acc;
    logic [ddrm_pkg::SU_W-1:0]         r_mcand, n_mcand;
    logic [ddrm_pkg::MPLR_W-1:0]       r_mplr, n_mplr;
    logic [ddrm_pkg::REM_W-1:0]        r_rem, n_rem;
    logic [ddrm_pkg::REM_W-1:0]        r_den, n_den;
    logic [ddrm_pkg::REM_W:0]          w_trial;
    logic [ddrm_pkg::REM_W:0]          w_diff;

    assign o_rsp.done = r_done;
    assign o_rsp.acc  = r_acc;

    assign w_trial = {r_rem, r_acc[ddrm_pkg::SU_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    // one step per cycle
    always_comb begin
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_mplr  = r_mplr;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        if (i_cmd.start) begin
            n_acc   = (i_cmd.op == ddrm_pkg::SU_MUL) ? '0 : i_cmd.opa;
            n_mcand = i_cmd.opa;
            n_mplr  = i_cmd.opb;
            n_rem   = i_cmd.rem;
            n_den   = i_cmd.den;
            n_cnt   = i_cmd.count;
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            case (r_op)
                ddrm_pkg::SU_MUL: begin
                    if (r_mplr[0]) begin
                        n_acc = r_acc + r_mcand;
                    end
                    n_mcand = r_mcand << 1;
                    n_mplr  = r_mplr >> 1;
                end
                ddrm_pkg::SU_DIV: begin
                    // trial subtract of the divisor from the shifted remainder
                    if (!w_diff[ddrm_pkg::REM_W]) begin
                        n_rem = w_diff[ddrm_pkg::REM_W-1:0];
                        n_acc = {r_acc[ddrm_pkg::SU_W-2:0], 1'b1};
                    end else begin
                        n_rem = w_trial[ddrm_pkg::REM_W-1:0];
                        n_acc = {r_acc[ddrm_pkg::SU_W-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ddrm_pkg::SU_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_cnt  <= n_cnt;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
            end else if (r_busy && r_cnt == ddrm_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_mplr  <= n_mplr;
        r_rem   <= n_rem;
        r_den   <= n_den;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ddrm_checker.sv =====
// ----------------------------------------------------------------------------
// ddrm_checker
// Port-level checks for the mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire ddrm_pkg::t_out o_out,
    input wire logic          pready
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before accept");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a clipped side sits at full scale
    a_lclip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.left_clipped |->
            (o_out.left_drive == ddrm_pkg::THR_FULL) ||
            (o_out.left_drive == (ddrm_pkg::THROTTLE_BITS'(0) - ddrm_pkg::THR_FULL)))
        else $error("left clip without full throttle");

    a_rclip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.right_clipped |->
            (o_out.right_drive == ddrm_pkg::THR_FULL) ||
            (o_out.right_drive == (ddrm_pkg::THROTTLE_BITS'(0) - ddrm_pkg::THR_FULL)))
        else $error("right clip without full throttle");

    // the APB port never stalls
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind diff_drive_ramped_mixer_top ddrm_checker u_ddrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .pready      (pready)
);

`default_nettype wire
